@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, a, c)
`define CHK_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ hw/rtl/chmc_pkg.sv @@
// Package with the types, constants and commands of the convex hull block.
package chmc_pkg;
  localparam int MaxPoints  = 64;
  localparam int CoordBits  = 16;
  localparam int StackDepth = 2 * MaxPoints;
  localparam int IdxW       = $clog2(MaxPoints);
  localparam int CntW       = $clog2(MaxPoints + 1);
  localparam int SpW        = $clog2(StackDepth + 1);
  localparam int ProdW      = 2 * (CoordBits + 1);

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SORT_RD, ST_SORT_CMP, ST_SORT_WR,
    ST_CH_RD, ST_CH_CMP, ST_CH_PUSH, ST_OUT_RD, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_LOWER, PH_UPPER
  } phase_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic store;     // store the input point
    logic clr_ovf;
    logic set_ovf;
    logic sort_init; // i = 1, read key
    logic sort_rd;   // read store[j-1]
    logic sort_shift;// store[j] = store[j-1], j--
    logic sort_put;  // store[j] = key, i++
    logic ch_init;   // start lower chain
    logic ch_rd;     // read two stack tops and the point
    logic ch_pop;
    logic ch_push;   // push point, advance index
    logic up_init;   // start upper chain
    logic out_init;
    logic out_rd;
    logic out_adv;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic sort_done;   // i >= count
    logic sort_move;   // j > 0 and store[j-1] > key
    logic ch_done;     // no point left in this phase
    logic ch_can_pop;  // depth enough and bad turn
    logic out_last;
    logic upper;       // upper chain in progress
  } stat_t;
endpackage

@@ hw/rtl/chmc_datapath.sv @@
// Datapath: point memory, stack memory, cross product and output register.
module chmc_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  chmc_pkg::cmd_t        cmd,
  output chmc_pkg::stat_t       stat,
  input  chmc_pkg::coord_t      in_x,
  input  chmc_pkg::coord_t      in_y,
  output chmc_pkg::coord_t      o_x,
  output chmc_pkg::coord_t      o_y,
  output logic                  o_ovf,
  output logic [chmc_pkg::CntW-1:0] o_cnt
);
  localparam int W  = chmc_pkg::CoordBits;
  localparam int D  = W + 1;
  localparam int PW = chmc_pkg::ProdW;

  logic [2*W-1:0] pmem [chmc_pkg::MaxPoints];
  logic [2*W-1:0] smem [chmc_pkg::StackDepth];

  logic [chmc_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic [chmc_pkg::CntW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [chmc_pkg::SpW-1:0]  sp_r, sp_nxt, base_r, base_nxt, oi_r, oi_nxt;
  logic ovf_r, ovf_nxt, up_r, up_nxt;
  logic [2*W-1:0] key_r, prv_r, a_r, b_r, p_r, oq_r;
  logic [chmc_pkg::CntW-1:0] pidx;
  logic signed [D-1:0] ax, ay, bx, by;
  logic signed [PW-1:0] m1_r, m2_r;
  logic signed [PW:0] cr;

  // Point index for the chain passes.
  assign pidx = up_r ? (i_r - 1'b1) : i_r;

  always_ff @(posedge clk) begin
    if (cmd.store)
      pmem[cnt_r[chmc_pkg::IdxW-1:0]] <= {in_x, in_y};
    if (cmd.sort_shift)
      pmem[j_r[chmc_pkg::IdxW-1:0]] <= prv_r;
    else if (cmd.sort_put)
      pmem[j_r[chmc_pkg::IdxW-1:0]] <= key_r;
    // A second point that is being stored right now is taken straight from the input.
    if (cmd.sort_init)
      key_r <= (cmd.store && cnt_r == 1) ? {in_x, in_y} : pmem[1];
    else if (cmd.sort_put)
      key_r <= pmem[i_r[chmc_pkg::IdxW-1:0] + 1'b1];
    if (cmd.sort_rd)
      prv_r <= pmem[j_r[chmc_pkg::IdxW-1:0] - 1'b1];
    if (cmd.ch_rd)
      p_r <= pmem[pidx[chmc_pkg::IdxW-1:0]];
    if (cmd.ch_push && sp_r < chmc_pkg::StackDepth)
      smem[sp_r[$clog2(chmc_pkg::StackDepth)-1:0]] <= p_r;
    if (cmd.ch_rd) begin
      a_r <= smem[sp_r[$clog2(chmc_pkg::StackDepth)-1:0] - 2'd2];
      b_r <= smem[sp_r[$clog2(chmc_pkg::StackDepth)-1:0] - 1'b1];
    end
    if (cmd.out_rd)
      oq_r <= (cnt_r == 1) ? pmem[0] : smem[oi_r[$clog2(chmc_pkg::StackDepth)-1:0]];
  end

  // Cross product terms, registered before the subtract.
  assign ax = D'(signed'(b_r[2*W-1:W])) - D'(signed'(a_r[2*W-1:W]));
  assign ay = D'(signed'(b_r[W-1:0]))   - D'(signed'(a_r[W-1:0]));
  assign bx = D'(signed'(p_r[2*W-1:W])) - D'(signed'(a_r[2*W-1:W]));
  assign by = D'(signed'(p_r[W-1:0]))   - D'(signed'(a_r[W-1:0]));
  always_ff @(posedge clk) begin
    m1_r <= ax * by;
    m2_r <= ay * bx;
  end
  assign cr = (PW+1)'(m1_r) - (PW+1)'(m2_r);

  always_comb begin
    cnt_nxt = cnt_r; i_nxt = i_r; j_nxt = j_r; sp_nxt = sp_r;
    base_nxt = base_r; oi_nxt = oi_r; ovf_nxt = ovf_r; up_nxt = up_r;
    if (cmd.store) cnt_nxt = cnt_r + 1'b1;
    if (cmd.set_ovf) ovf_nxt = 1'b1;
    if (cmd.sort_init) begin
      i_nxt = chmc_pkg::CntW'(1); j_nxt = chmc_pkg::CntW'(1);
    end
    if (cmd.sort_shift) j_nxt = j_r - 1'b1;
    if (cmd.sort_put) begin i_nxt = i_r + 1'b1; j_nxt = i_r + 1'b1; end
    if (cmd.ch_init) begin i_nxt = '0; sp_nxt = '0; up_nxt = 1'b0; end
    if (cmd.ch_pop) sp_nxt = sp_r - 1'b1;
    if (cmd.ch_push) begin
      if (sp_r < chmc_pkg::StackDepth) sp_nxt = sp_r + 1'b1;
      i_nxt = up_r ? (i_r - 1'b1) : (i_r + 1'b1);
    end
    if (cmd.up_init) begin
      up_nxt = 1'b1; i_nxt = cnt_r - 1'b1; base_nxt = sp_r + 1'b1;
    end
    if (cmd.out_init) oi_nxt = '0;
    if (cmd.out_adv) oi_nxt = oi_r + 1'b1;
    if (cmd.clear) begin cnt_nxt = '0; ovf_nxt = 1'b0; end
    if (cmd.clr_ovf) ovf_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; ovf_r <= 1'b0; up_r <= 1'b0; sp_r <= '0;
    end else begin
      cnt_r <= cnt_nxt; ovf_r <= ovf_nxt; up_r <= up_nxt; sp_r <= sp_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; base_r <= base_nxt; oi_r <= oi_nxt;
  end

  logic signed [W-1:0] kx, ky, qx, qy;
  logic [chmc_pkg::SpW-1:0] nres;
  assign kx = key_r[2*W-1:W];
  assign ky = key_r[W-1:0];
  assign qx = prv_r[2*W-1:W];
  assign qy = prv_r[W-1:0];
  // Result count: stack depth less one, capped at capacity.
  assign nres = (sp_r - 1'b1 > chmc_pkg::MaxPoints) ?
                chmc_pkg::SpW'(chmc_pkg::MaxPoints) : sp_r - 1'b1;

  always_comb begin
    stat.full       = (cnt_r == chmc_pkg::MaxPoints);
    stat.sort_done  = (i_r >= cnt_r);
    stat.sort_move  = (j_r != 0) && ((qx > kx) || (qx == kx && qy > ky));
    stat.ch_done    = up_r ? (i_r == 0) : (i_r == cnt_r);
    stat.ch_can_pop = (up_r ? (sp_r >= base_r) : (sp_r >= 2)) && (cr <= 0);
    stat.out_last   = (cnt_r == 1) || (oi_r + 1'b1 == nres);
    stat.upper      = up_r;
  end

  assign o_x   = oq_r[2*W-1:W];
  assign o_y   = oq_r[W-1:0];
  assign o_ovf = ovf_r;
  assign o_cnt = cnt_r;
endmodule

@@ hw/rtl/chmc_ctrl.sv @@
// Controller state machine sequencing load, sort, chain and output.
module chmc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_last,
  input  chmc_pkg::stat_t  stat,
  input  logic [chmc_pkg::CntW-1:0] cnt,
  output chmc_pkg::cmd_t   cmd
);
  chmc_pkg::state_t state_r, state_nxt;
  logic [1:0] wait_r, wait_nxt;
  logic last_r, last_nxt;
  logic acc;
  logic to_upper, to_out;

  assign acc = in_valid && in_ready;

  chmc_seq u_seq (
    .state(state_r), .stat, .up(stat.upper), .to_upper, .to_out
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chmc_pkg::ST_LOAD; wait_r <= '0; last_r <= 1'b0;
    end else begin
      state_r <= state_nxt; wait_r <= wait_nxt; last_r <= last_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r; wait_nxt = wait_r; last_nxt = last_r;
    unique case (state_r)
      chmc_pkg::ST_LOAD:
        if (acc && in_last) begin
          if (cnt == 0 && stat.full) state_nxt = chmc_pkg::ST_LOAD;
          else if (cnt == 0) state_nxt = chmc_pkg::ST_OUT_RD;
          else state_nxt = chmc_pkg::ST_SORT_RD;
        end
      chmc_pkg::ST_SORT_RD:
        state_nxt = stat.sort_done ? chmc_pkg::ST_CH_RD : chmc_pkg::ST_SORT_CMP;
      chmc_pkg::ST_SORT_CMP:
        state_nxt = stat.sort_move ? chmc_pkg::ST_SORT_RD : chmc_pkg::ST_SORT_WR;
      chmc_pkg::ST_SORT_WR:
        state_nxt = chmc_pkg::ST_SORT_RD;
      chmc_pkg::ST_CH_RD:
        if (to_upper) state_nxt = chmc_pkg::ST_CH_RD;
        else if (to_out) state_nxt = chmc_pkg::ST_OUT_RD;
        else begin
          wait_nxt = 2'd2;
          state_nxt = chmc_pkg::ST_CH_CMP;
        end
      chmc_pkg::ST_CH_CMP:
        if (wait_r != 0) wait_nxt = wait_r - 1'b1;
        else state_nxt = stat.ch_can_pop ? chmc_pkg::ST_CH_RD : chmc_pkg::ST_CH_PUSH;
      chmc_pkg::ST_CH_PUSH:
        state_nxt = chmc_pkg::ST_CH_RD;
      chmc_pkg::ST_OUT_RD: begin
        last_nxt = stat.out_last;
        state_nxt = chmc_pkg::ST_OUT;
      end
      chmc_pkg::ST_OUT:
        if (out_ready) state_nxt = last_r ? chmc_pkg::ST_LOAD : chmc_pkg::ST_OUT_RD;
      default: state_nxt = chmc_pkg::ST_LOAD;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    in_ready = 1'b0; out_valid = 1'b0;
    out_last = last_r;
    unique case (state_r)
      chmc_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        cmd.store   = acc && !stat.full;
        cmd.set_ovf = acc && stat.full;
        if (acc && in_last) begin
          cmd.sort_init = 1'b1;
          if (cnt == 0 && stat.full) cmd.clear = 1'b1;
          else if (cnt == 0) cmd.out_init = 1'b1;
        end
      end
      chmc_pkg::ST_SORT_RD: begin
        cmd.sort_rd = !stat.sort_done;
        if (stat.sort_done) begin
          cmd.ch_init = !(cnt == 1);
        end
      end
      chmc_pkg::ST_SORT_CMP: cmd.sort_shift = stat.sort_move;
      chmc_pkg::ST_SORT_WR: cmd.sort_put = 1'b1;
      chmc_pkg::ST_CH_RD: begin
        cmd.up_init  = to_upper;
        cmd.out_init = to_out;
        cmd.ch_rd    = !to_upper && !to_out;
      end
      chmc_pkg::ST_CH_CMP:
        if (wait_r == 0) cmd.ch_pop = stat.ch_can_pop;
      chmc_pkg::ST_CH_PUSH: cmd.ch_push = 1'b1;
      chmc_pkg::ST_OUT_RD: cmd.out_rd = 1'b1;
      chmc_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.out_adv = 1'b1;
          cmd.clear = last_r;
        end
      end
      default: cmd = '0;
    endcase
  end
endmodule

@@ hw/rtl/chmc_seq.sv @@
// Chain sequencing helper: finishes each pass and starts the next.
module chmc_seq (
  input  chmc_pkg::state_t  state,
  input  chmc_pkg::stat_t   stat,
  input  logic              up,
  output logic              to_upper,
  output logic              to_out
);
  always_comb begin
    to_upper = (state == chmc_pkg::ST_CH_RD) && stat.ch_done && !up;
    to_out   = (state == chmc_pkg::ST_CH_RD) && stat.ch_done && up;
  end
endmodule

@@ hw/rtl/convex_hull_monotone_chain.sv @@
// Top level of the monotone chain convex hull block.
// Points are taken one transaction per cycle while loading and stored
// (up to 64; further points are discarded and flagged). After the flagged
// last point the block insertion-sorts the store by x then y over its point
// memory (each shift reads the entry below and moves it up, and each key is
// then written into its place), then builds the lower and upper chains on a
// stack memory; each turn test reads the stack tops, registers the two
// products, then subtracts and compares, and each push is a step of its own.
// Hull vertices then leave one at a time, each read before it is offered,
// counterclockwise from the leftmost-lowest point, the final one flagged. No
// new point is taken until the last vertex has been delivered. The memories
// need no clearing pass after reset.
`include "assert_macros.svh"
module convex_hull_monotone_chain (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  chmc_pkg::coord_t        in_point_x,
  input  chmc_pkg::coord_t        in_point_y,
  input  logic                    in_last_point,
  output logic                    out_valid,
  input  logic                    out_ready,
  output chmc_pkg::coord_t        out_hull_x,
  output chmc_pkg::coord_t        out_hull_y,
  output logic                    out_last_vertex,
  output logic                    out_dropped_points
);
  chmc_pkg::cmd_t  cmd, cmd_c;
  chmc_pkg::stat_t stat;
  logic [chmc_pkg::CntW-1:0] cnt;

  chmc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_last(in_last_point),
    .out_valid, .out_ready, .out_last(out_last_vertex),
    .stat, .cnt, .cmd(cmd_c)
  );

  always_comb begin
    cmd = cmd_c;
  end

  chmc_datapath u_dp (
    .clk, .rst_n, .cmd, .stat, .in_x(in_point_x), .in_y(in_point_y),
    .o_x(out_hull_x), .o_y(out_hull_y), .o_ovf(out_dropped_points), .o_cnt(cnt)
  );

  `CHK_NEXT(a_no_accept_while_out, clk, rst_n, out_valid && !out_ready, out_valid)
  `CHK_IMPL(a_excl_hs, clk, rst_n, out_valid, !in_ready)
endmodule
